[hdl/shell_command_lexer_defines.svh]
// Assertion macros shared by the lexer RTL.
`ifndef SHELL_COMMAND_LEXER_DEFINES_SVH
`define SHELL_COMMAND_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCLX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SCLX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sclx_pkg.sv]
`default_nettype none

package sclx_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int RAW_BITS    = 16;
  localparam int CHAR_BITS   = 8;
  localparam int WIDE_BITS   = LENGTH_BITS + RAW_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [CHAR_BITS-1:0]   char_t;
  typedef logic [LENGTH_BITS-1:0] count_t;
  typedef logic [RAW_BITS-1:0]    raw_t;

  typedef enum logic [3:0] {
    K_CHAR   = 4'd0,
    K_WORD   = 4'd1,
    K_FD     = 4'd2,
    K_PIPE   = 4'd3,
    K_OR     = 4'd4,
    K_BG     = 4'd5,
    K_AND    = 4'd6,
    K_OUT    = 4'd7,
    K_APPEND = 4'd8,
    K_IN     = 4'd9,
    K_SEMI   = 4'd10,
    K_EOF    = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_BAR  = 2'd1,
    OP_AMP  = 2'd2,
    OP_GT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SCAN_START  = 2'd0,
    SCAN_SIGN   = 2'd1,
    SCAN_DIGITS = 2'd2,
    SCAN_FAIL   = 2'd3
  } scan_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_BAR    = 8'h7C;

  typedef struct packed {
    kind_t kind;
    char_t ch;
    raw_t  len;
    logic  last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t mk_result(kind_t k, char_t c, raw_t l);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.len  = l;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic raw_t sat_len(count_t c);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(c);
    if (w > WIDE_BITS'({RAW_BITS{1'b1}})) begin
      return {RAW_BITS{1'b1}};
    end
    return w[RAW_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/sclx_lex.sv]
`default_nettype none

module sclx_lex (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  sclx_pkg::char_t  ch,
  input  logic             eol_flag,
  output sclx_pkg::step_t  step
);
  import sclx_pkg::*;

  `include "shell_command_lexer_defines.svh"

  op_t    pend;
  logic   word_open;
  logic   sq;
  logic   dq;
  scan_t  scan;
  logic   hadq;
  count_t cnt;

  op_t    pend_next;
  logic   word_open_next;
  logic   sq_next;
  logic   dq_next;
  scan_t  scan_next;
  logic   hadq_next;
  count_t cnt_next;

  always_comb begin
    result_t    res [2];
    logic [1:0] n;
    logic       eol;
    logic       blank;
    logic       opb;
    logic       do_fresh;
    logic       do_word;
    char_t      twin;
    kind_t      k1;
    kind_t      k2;

    res[0]         = mk_result(K_CHAR, '0, '0);
    res[1]         = mk_result(K_CHAR, '0, '0);
    n              = 2'd0;
    eol            = eol_flag || (ch == CH_NUL);
    blank          = (ch == CH_SPACE) || (ch == CH_TAB);
    opb            = (ch == CH_BAR) || (ch == CH_AMP) || (ch == CH_SEMI) ||
                     (ch == CH_LT) || (ch == CH_GT);
    do_fresh       = 1'b0;
    do_word        = 1'b0;
    pend_next      = pend;
    word_open_next = word_open;
    sq_next        = sq;
    dq_next        = dq;
    scan_next      = scan;
    hadq_next      = hadq;
    cnt_next       = cnt;

    case (pend)
      OP_BAR: begin
        twin = CH_BAR;
        k1   = K_PIPE;
        k2   = K_OR;
      end
      OP_AMP: begin
        twin = CH_AMP;
        k1   = K_BG;
        k2   = K_AND;
      end
      default: begin
        twin = CH_GT;
        k1   = K_OUT;
        k2   = K_APPEND;
      end
    endcase

    if (pend != OP_NONE) begin
      pend_next = OP_NONE;
      if (!eol && ch == twin) begin
        res[n[0]] = mk_result(k2, '0, RAW_BITS'(2));
        n = n + 2'd1;
      end else begin
        res[n[0]] = mk_result(k1, '0, RAW_BITS'(1));
        n = n + 2'd1;
        if (eol) begin
          res[n[0]] = mk_result(K_EOF, '0, '0);
          n = n + 2'd1;
          word_open_next = 1'b0;
          sq_next        = 1'b0;
          dq_next        = 1'b0;
          scan_next      = SCAN_START;
          hadq_next      = 1'b0;
          cnt_next       = '0;
        end else begin
          do_fresh = 1'b1;
        end
      end
    end else if (word_open) begin
      if (eol) begin
        res[n[0]] = mk_result(K_WORD, '0, sat_len(cnt));
        n = n + 2'd1;
        res[n[0]] = mk_result(K_EOF, '0, '0);
        n = n + 2'd1;
        word_open_next = 1'b0;
        sq_next        = 1'b0;
        dq_next        = 1'b0;
        scan_next      = SCAN_START;
        hadq_next      = 1'b0;
        cnt_next       = '0;
      end else if (!sq && !dq && (blank || opb)) begin
        if (!hadq && scan == SCAN_DIGITS && (ch == CH_LT || ch == CH_GT)) begin
          res[n[0]] = mk_result(K_FD, '0, sat_len(cnt));
        end else begin
          res[n[0]] = mk_result(K_WORD, '0, sat_len(cnt));
        end
        n = n + 2'd1;
        word_open_next = 1'b0;
        sq_next        = 1'b0;
        dq_next        = 1'b0;
        do_fresh       = 1'b1;
      end else begin
        do_word = 1'b1;
      end
    end else if (eol) begin
      res[n[0]] = mk_result(K_EOF, '0, '0);
      n = n + 2'd1;
      word_open_next = 1'b0;
      sq_next        = 1'b0;
      dq_next        = 1'b0;
      scan_next      = SCAN_START;
      hadq_next      = 1'b0;
      cnt_next       = '0;
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh && !blank) begin
      case (ch)
        CH_LT: begin
          res[n[0]] = mk_result(K_IN, '0, RAW_BITS'(1));
          n = n + 2'd1;
        end
        CH_SEMI: begin
          res[n[0]] = mk_result(K_SEMI, '0, RAW_BITS'(1));
          n = n + 2'd1;
        end
        CH_BAR: pend_next = OP_BAR;
        CH_AMP: pend_next = OP_AMP;
        CH_GT:  pend_next = OP_GT;
        default: begin
          word_open_next = 1'b1;
          sq_next        = 1'b0;
          dq_next        = 1'b0;
          scan_next      = SCAN_START;
          hadq_next      = 1'b0;
          cnt_next       = '0;
          do_word        = 1'b1;
        end
      endcase
    end

    if (do_word) begin
      if (cnt_next != {LENGTH_BITS{1'b1}}) begin
        cnt_next = cnt_next + LENGTH_BITS'(1);
      end
      if (ch == CH_SQUOTE && !dq_next) begin
        sq_next   = !sq_next;
        hadq_next = 1'b1;
      end else if (ch == CH_DQUOTE && !sq_next) begin
        dq_next   = !dq_next;
        hadq_next = 1'b1;
      end else begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          scan_next = (scan_next == SCAN_FAIL) ? SCAN_FAIL : SCAN_DIGITS;
        end else if ((ch == CH_PLUS || ch == CH_MINUS) && scan_next == SCAN_START) begin
          scan_next = SCAN_SIGN;
        end else begin
          scan_next = SCAN_FAIL;
        end
        res[n[0]] = mk_result(K_CHAR, ch, '0);
        n = n + 2'd1;
      end
    end

    if (n != 2'd0) begin
      res[n[1]].last = 1'b1;
    end

    step.num = n;
    step.r0  = res[0];
    step.r1  = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= OP_NONE;
      word_open <= 1'b0;
      sq        <= 1'b0;
      dq        <= 1'b0;
      scan      <= SCAN_START;
      hadq      <= 1'b0;
      cnt       <= '0;
    end else if (accept) begin
      pend      <= pend_next;
      word_open <= word_open_next;
      sq        <= sq_next;
      dq        <= dq_next;
      scan      <= scan_next;
      hadq      <= hadq_next;
      cnt       <= cnt_next;
    end
  end

  `SCLX_ASSERT_NOW(a_quote_excl, 1'b1, !(sq && dq), "both quote modes open")
  `SCLX_ASSERT_NOW(a_quote_in_word, sq || dq, word_open, "quote open outside a word")
  `SCLX_ASSERT_NOW(a_pend_no_word, pend != OP_NONE, !word_open, "operator held inside a word")
  `SCLX_ASSERT_NEXT(a_eol_idle, accept && eol_flag, !word_open && pend == OP_NONE && cnt == '0,
                    "state not cleared after end of line")

endmodule

`default_nettype wire

[hdl/shell_command_lexer.sv]
// Channel  Dir  tdata                               tuser           tlast
// s_axis   in   [7:0] char_in                       -               end_of_line
// m_axis   out  [7:0] char_value, [23:8] token_len  [3:0] token_kind last_of_item
//
// One input item is lexed in the cycle it is accepted; items may arrive every cycle.
// Each item gives 0, 1 or 2 results into a 4-entry result queue; with m_axis_tready high
// the output drains one result per cycle: 1 item/cycle for items with at most one result.
// s_axis_tready is high while the queue has room for two results.
// Synchronous active-high rst clears the lexer state and empties the queue.
`default_nettype none

module shell_command_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] char_value, [23:8] token_len
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast
);
  import sclx_pkg::*;

  `include "shell_command_lexer_defines.svh"

  step_t                step;
  logic                 acc;
  logic                 pop;
  result_t              q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QPTR_BITS:0]   qcount;
  logic [QPTR_BITS-1:0] wptr_inc;
  logic [QPTR_BITS-1:0] wptr_next;
  logic [QPTR_BITS:0]   qcount_next;
  result_t              head;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign pop = m_axis_tvalid && m_axis_tready;

  sclx_lex u_lex (
    .clk      (clk),
    .rst      (rst),
    .accept   (acc),
    .ch       (s_axis_tdata),
    .eol_flag (s_axis_tlast),
    .step     (step)
  );

  assign s_axis_tready = (qcount <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));
  assign wptr_inc      = wptr + QPTR_BITS'(1);

  always_comb begin
    wptr_next   = wptr;
    qcount_next = qcount;
    if (acc) begin
      wptr_next   = wptr + QPTR_BITS'(step.num);
      qcount_next = qcount + (QPTR_BITS+1)'(step.num);
    end
    if (pop) begin
      qcount_next = qcount_next - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      qcount <= '0;
    end else begin
      wptr   <= wptr_next;
      qcount <= qcount_next;
      if (pop) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && step.num != 2'd0) begin
      q[wptr] <= step.r0;
    end
    if (acc && step.num == 2'd2) begin
      q[wptr_inc] <= step.r1;
    end
  end

  assign head          = q[rptr];
  assign m_axis_tvalid = (qcount != '0);
  assign m_axis_tdata  = {head.len, head.ch};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  `SCLX_ASSERT_NOW(a_q_bound, 1'b1, qcount <= (QPTR_BITS+1)'(QUEUE_DEPTH), "queue overfilled")
  `SCLX_ASSERT_NEXT(a_eol_out, acc && s_axis_tlast, m_axis_tvalid, "no result after end of line")
  `SCLX_ASSERT_NEXT(a_q_hold, !acc && !pop, $stable(qcount), "queue level moved while idle")

endmodule

`default_nettype wire

[sim/tb_shell_command_lexer.sv]
`default_nettype none

module tb_shell_command_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import sclx_pkg::*;

  typedef struct {
    char_t c;
    bit    eol;
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
  logic        s_axis_tlast = 1'b0; // end_of_line
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] char_value, [23:8] token_len
  logic [3:0]  m_axis_tuser;        // [3:0] token_kind
  logic        m_axis_tlast;        // last_of_item

  shell_command_lexer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_byte_t bytes_to_send[$];
  line_byte_t next_byte;
  result_t    tokens_due[$];
  result_t    step_out[$];
  result_t    want;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  queued_items = 0;
  int  items_lexed = 0;
  int  tokens_seen = 0;
  int  error_count = 0;
  int  kind_count[16];
  bit  item_taken = 1'b0;

  // Lexer state as the block should hold it
  op_t    held_op = OP_NONE;
  bit     in_word = 1'b0;
  bit     in_sq = 1'b0;
  bit     in_dq = 1'b0;
  bit     word_quoted = 1'b0;
  scan_t  num_state = SCAN_START;
  count_t word_len = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results still due", tokens_due.size());
    $display("tb_shell_command_lexer failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic bit is_op_char(char_t c);
    return c == CH_BAR || c == CH_AMP || c == CH_SEMI || c == CH_LT || c == CH_GT;
  endfunction

  function automatic void emit(kind_t k, char_t c, raw_t l);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.len  = l;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void clear_lexer();
    held_op     = OP_NONE;
    in_word     = 1'b0;
    in_sq       = 1'b0;
    in_dq       = 1'b0;
    num_state   = SCAN_START;
    word_quoted = 1'b0;
    word_len    = '0;
  endfunction

  function automatic void count_byte();
    if (word_len != '1) begin
      word_len++;
    end
  endfunction

  function automatic void lex_word_char(char_t c);
    if (c == CH_SQUOTE && !in_dq) begin
      in_sq = !in_sq;
      word_quoted = 1'b1;
      count_byte();
    end else if (c == CH_DQUOTE && !in_sq) begin
      in_dq = !in_dq;
      word_quoted = 1'b1;
      count_byte();
    end else begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num_state = (num_state == SCAN_FAIL) ? SCAN_FAIL : SCAN_DIGITS;
      end else if ((c == CH_PLUS || c == CH_MINUS) && num_state == SCAN_START) begin
        num_state = SCAN_SIGN;
      end else begin
        num_state = SCAN_FAIL;
      end
      count_byte();
      emit(K_CHAR, c, '0);
    end
  endfunction

  function automatic void lex_fresh(char_t c);
    if (c == CH_SPACE || c == CH_TAB) begin
      return;
    end
    case (c)
      CH_LT:   emit(K_IN, '0, 16'd1);
      CH_SEMI: emit(K_SEMI, '0, 16'd1);
      CH_BAR:  held_op = OP_BAR;
      CH_AMP:  held_op = OP_AMP;
      CH_GT:   held_op = OP_GT;
      default: begin
        in_word     = 1'b1;
        in_sq       = 1'b0;
        in_dq       = 1'b0;
        num_state   = SCAN_START;
        word_quoted = 1'b0;
        word_len    = '0;
        lex_word_char(c);
      end
    endcase
  endfunction

  function automatic void close_word(kind_t k);
    emit(k, '0, raw_t'(word_len));
    in_word = 1'b0;
    in_sq   = 1'b0;
    in_dq   = 1'b0;
  endfunction

  // Work out the tokens one accepted byte gives and queue them
  function automatic void lex_step(char_t c, logic tl);
    bit      eol;
    char_t   twin;
    kind_t   one;
    kind_t   two;
    result_t r;
    eol = tl || c == CH_NUL;
    step_out.delete();
    if (held_op != OP_NONE) begin
      case (held_op)
        OP_BAR:  begin twin = CH_BAR; one = K_PIPE; two = K_OR; end
        OP_AMP:  begin twin = CH_AMP; one = K_BG;   two = K_AND; end
        default: begin twin = CH_GT;  one = K_OUT;  two = K_APPEND; end
      endcase
      held_op = OP_NONE;
      if (!eol && c == twin) begin
        emit(two, '0, 16'd2);
      end else begin
        emit(one, '0, 16'd1);
        if (eol) begin
          emit(K_EOF, '0, '0);
          clear_lexer();
        end else begin
          lex_fresh(c);
        end
      end
    end else if (in_word) begin
      if (eol) begin
        close_word(K_WORD);
        emit(K_EOF, '0, '0);
        clear_lexer();
      end else if (!in_sq && !in_dq && (c == CH_SPACE || c == CH_TAB || is_op_char(c))) begin
        close_word((!word_quoted && num_state == SCAN_DIGITS && (c == CH_LT || c == CH_GT)) ?
                   K_FD : K_WORD);
        lex_fresh(c);
      end else begin
        lex_word_char(c);
      end
    end else if (eol) begin
      emit(K_EOF, '0, '0);
      clear_lexer();
    end else begin
      lex_fresh(c);
    end
    foreach (step_out[i]) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      tokens_due.push_back(r);
    end
  endfunction

  function automatic void push_byte(char_t c, bit eol);
    line_byte_t b;
    b.c   = c;
    b.eol = eol;
    bytes_to_send.push_back(b);
    queued_items++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], 1'b0);
    end
  endfunction

  function automatic char_t digit_char();
    return CH_ZERO + char_t'($urandom_range(0, 9));
  endfunction

  function automatic char_t sign_char();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  function automatic char_t quote_char();
    return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic char_t plain_char();
    char_t c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = "a" + char_t'($urandom_range(0, 25));
      4, 5:       c = digit_char();
      6:          c = sign_char();
      default: begin
        c = char_t'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
               is_op_char(c)) begin
          c = char_t'($urandom_range(1, 255));
        end
      end
    endcase
    return c;
  endfunction

  // Anything may sit inside quotes but the closing quote itself
  function automatic char_t quoted_char(char_t q);
    char_t c;
    case ($urandom_range(0, 5))
      0:       c = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      1:       c = quote_char();
      2: begin
        case ($urandom_range(0, 4))
          0:       c = CH_BAR;
          1:       c = CH_AMP;
          2:       c = CH_SEMI;
          3:       c = CH_LT;
          default: c = CH_GT;
        endcase
      end
      default: c = plain_char();
    endcase
    return (c == q) ? plain_char() : c;
  endfunction

  function automatic void gen_quoted(bit closed);
    char_t q;
    q = quote_char();
    push_byte(q, 1'b0);
    repeat ($urandom_range(0, 4)) push_byte(quoted_char(q), 1'b0);
    if (closed) begin
      push_byte(q, 1'b0);
    end
  endfunction

  function automatic void gen_redirect();
    case ($urandom_range(0, 2))
      0:       push_byte(CH_LT, 1'b0);
      1:       push_byte(CH_GT, 1'b0);
      default: begin push_byte(CH_GT, 1'b0); push_byte(CH_GT, 1'b0); end
    endcase
  endfunction

  function automatic void gen_word();
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 6)) push_byte(plain_char(), 1'b0);
      3, 4: begin
        if ($urandom_range(0, 1)) begin
          push_byte(sign_char(), 1'b0);
        end
        repeat ($urandom_range(1, 3)) push_byte(digit_char(), 1'b0);
        gen_redirect();
      end
      5: begin
        case ($urandom_range(0, 2))
          0: push_byte(sign_char(), 1'b0);
          1: begin
            push_byte(digit_char(), 1'b0);
            push_byte(CH_SQUOTE, 1'b0);
            push_byte(digit_char(), 1'b0);
            push_byte(CH_SQUOTE, 1'b0);
          end
          default: begin
            push_byte(digit_char(), 1'b0);
            push_byte("x", 1'b0);
          end
        endcase
        gen_redirect();
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(plain_char(), 1'b0);
          end else begin
            gen_quoted(1'b1);
          end
        end
      end
    endcase
  endfunction

  function automatic void gen_op();
    case ($urandom_range(0, 7))
      0: push_byte(CH_BAR, 1'b0);
      1: begin push_byte(CH_BAR, 1'b0); push_byte(CH_BAR, 1'b0); end
      2: push_byte(CH_AMP, 1'b0);
      3: begin push_byte(CH_AMP, 1'b0); push_byte(CH_AMP, 1'b0); end
      4: push_byte(CH_GT, 1'b0);
      5: begin push_byte(CH_GT, 1'b0); push_byte(CH_GT, 1'b0); end
      6: push_byte(CH_LT, 1'b0);
      default: push_byte(CH_SEMI, 1'b0);
    endcase
  endfunction

  function automatic void gen_line();
    repeat ($urandom_range(0, 6)) begin
      repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
      if ($urandom_range(0, 9) < 6) begin
        gen_word();
      end else begin
        gen_op();
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      gen_quoted(1'b0);
    end
    case ($urandom_range(0, 3))
      0:       push_byte(CH_NUL, 1'b0);
      1:       push_byte(CH_NUL, 1'b1);
      default: push_byte(char_t'($urandom_range(0, 255)), 1'b1);
    endcase
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 8)) begin
      push_byte(char_t'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
  endfunction

  // Drive inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || item_taken) begin
        if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_byte = bytes_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_byte.c;
          s_axis_tlast  <= next_byte.eol;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    item_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_step(s_axis_tdata, s_axis_tlast);
        items_lexed++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tokens_seen++;
        if (m_axis_tuser <= K_EOF) begin
          kind_count[m_axis_tuser]++;
        end
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d char %h len %0d last %b",
                                    m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
                                    m_axis_tlast));
        end else begin
          want = tokens_due.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.ch ||
              m_axis_tdata[23:8] !== want.len || m_axis_tlast !== want.last) begin
            report_mismatch($sformatf(
              "result %0d: got kind %0d char %h len %0d last %b, want %0d %h %0d %b",
              tokens_seen, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
              m_axis_tlast, want.kind, want.ch, want.len, want.last));
          end
        end
      end
    end
  end

  initial begin
    int op_total;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (p == 0) begin
        // fd with and without sign, append, in, quotes nesting, open quote at end of line
        push_text("\t2>>o -5<'a|\"'\"'");
        push_byte(8'hFF, 1'b1);
        // pipe, or, and, bg, semi, out flushed by a NUL byte
        push_text("|y||&&&;>");
        push_byte(CH_NUL, 1'b0);
      end
      queued_items = 0;
      while (queued_items < 200) begin
        if ($urandom_range(0, 99) < 85) begin
          gen_line();
        end else begin
          gen_noise();
        end
      end
      // hold off until everything in flight has drained
      while (bytes_to_send.size() != 0 || s_axis_tvalid || tokens_due.size() != 0) begin
        @(negedge clk);
      end
    end
    repeat (8) @(posedge clk);
    if (tokens_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", tokens_due.size()));
    end
    op_total = 0;
    for (int k = K_PIPE; k <= K_SEMI; k++) begin
      op_total += kind_count[k];
    end
    $display("lexed %0d bytes into %0d results: %0d chars, %0d words, %0d fd, %0d ops, %0d eof",
             items_lexed, tokens_seen, kind_count[K_CHAR], kind_count[K_WORD],
             kind_count[K_FD], op_total, kind_count[K_EOF]);
    $display("ran free, sender-idle, receiver-stall and mixed phases with a full drain each");
    if (error_count == 0) begin
      $display("tb_shell_command_lexer passed");
    end else begin
      $display("tb_shell_command_lexer failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/sclx_pkg.sv
hdl/sclx_lex.sv
hdl/shell_command_lexer.sv
sim/tb_shell_command_lexer.sv
